// ----- rtl/irecb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irecb_pkg
// Types and constants for the IR edge interval capture buffer.
// ----------------------------------------------------------------------------
package irecb_pkg;

  localparam int TICK_W         = 16;
  localparam int CNT_W          = 8;
  localparam int KIND_W         = 2;
  localparam int RIDX_W         = 7;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;
  localparam int DEF_STORE_DEPTH = 128;

  localparam logic [CNT_W-1:0]  CAP_RESET = 8'd128;
  localparam logic [CNT_W-1:0]  SAT_MAX   = 8'hFF;
  localparam logic [TICK_W-1:0] TICK_MAX  = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic              frame_done;
    logic [CNT_W-1:0]  segment_count;
    logic [CNT_W-1:0]  dropped_count;
    logic              rd_hit;
    logic              timeout_event;
  } res_t;

endpackage : irecb_pkg
`default_nettype wire

// ----- rtl/ir_edge_interval_capture_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ir_edge_interval_capture_buffer
// Captures tick intervals between IR receiver edges into a frame store with
// end-of-frame timeout, first-interval drop and saturating drop count.
// ----------------------------------------------------------------------------
//  channel | handshake                          | payload
//  --------+------------------------------------+--------------------------------
//  in      | in_valid / in_ready                | in_kind, in_read_index
//  out     | out_valid / out_ready              | frame_done, segment_count,
//          |                                    | dropped_count, read_duration,
//          |                                    | timeout_event
//  cfg     | APB write at cfg_psel&penable&pwrite | cfg_paddr, cfg_pwdata
//
//  One transfer per cycle sustained while the output is not stalled; in reaches
//  out through stage 1 and stage 2. Stage 1 updates the control state and issues
//  the store access; the store read data arrives with stage 2 and is selected
//  into the output register. A stalled output holds both stages; in_ready follows out_ready.
//  rst_n is synchronous; the interval store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module ir_edge_interval_capture_buffer #(
  parameter int STORE_DEPTH = irecb_pkg::DEF_STORE_DEPTH
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [irecb_pkg::KIND_W-1:0]        in_kind,
  input  wire  [irecb_pkg::RIDX_W-1:0]        in_read_index,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_frame_done,
  output logic [irecb_pkg::CNT_W-1:0]         out_segment_count,
  output logic [irecb_pkg::CNT_W-1:0]         out_dropped_count,
  output logic [irecb_pkg::TICK_W-1:0]        out_read_duration,
  output logic                                out_timeout_event,
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [irecb_pkg::APB_AW-1:0]        cfg_paddr,
  input  wire  [irecb_pkg::APB_DW-1:0]        cfg_pwdata,
  output logic [irecb_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                                cfg_pready
);
  import irecb_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

  logic [TICK_W-1:0] mem [STORE_DEPTH];
  logic [TICK_W-1:0] mem_q_r;

  logic [TICK_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic              armed_r, armed_nxt;
  logic              await_r, await_nxt;
  logic              frozen_r, frozen_nxt;
  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic [CNT_W-1:0]  drop_r, drop_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  eff_cap;

  logic              s1_valid_r;
  res_t              s1_res_r, s1_res_nxt;
  logic              s1_adv;
  logic              in_xfer;
  logic              cfg_wr;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CNT_W-1:0]  ridx_ext;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr[2] == REG_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? APB_DW'(cap_r) : '0;

  assign s1_adv   = ~out_valid | out_ready;
  assign in_ready = ~s1_valid_r | s1_adv;
  assign in_xfer  = in_valid & in_ready;

  assign eff_cap  = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
  assign ridx_ext = CNT_W'(in_read_index);
  assign rd_addr  = ridx_ext[AW-1:0];
  assign wr_addr  = stored_r[AW-1:0];

  always_comb begin
    tick_cnt_nxt = tick_cnt_r;
    armed_nxt    = armed_r;
    await_nxt    = await_r;
    frozen_nxt   = frozen_r;
    stored_nxt   = stored_r;
    drop_nxt     = drop_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    s1_res_nxt   = '0;
    if (in_xfer) begin
      case (in_kind)
        KIND_TICK: begin
          tick_cnt_nxt = tick_cnt_r + 1'b1;
          if (tick_cnt_r == TICK_MAX && armed_r) begin
            armed_nxt                = 1'b0;
            s1_res_nxt.timeout_event = 1'b1;
            if (stored_r != '0) begin
              frozen_nxt = 1'b1;
            end
          end
        end
        KIND_EDGE: begin
          tick_cnt_nxt = '0;
          armed_nxt    = 1'b1;
          if (!frozen_r) begin
            if (await_r) begin
              await_nxt = 1'b0;
            end else if (stored_r >= eff_cap) begin
              if (drop_r != SAT_MAX) begin
                drop_nxt = drop_r + 1'b1;
              end
            end else begin
              wr_en      = 1'b1;
              stored_nxt = stored_r + 1'b1;
            end
          end
        end
        KIND_RELEASE: begin
          stored_nxt = '0;
          drop_nxt   = '0;
          frozen_nxt = 1'b0;
          await_nxt  = 1'b1;
        end
        KIND_READ: begin
          rd_en = 1'b1;
          s1_res_nxt.rd_hit = (ridx_ext < stored_r) && (ridx_ext < DEPTH_C);
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end
    s1_res_nxt.frame_done    = frozen_nxt;
    s1_res_nxt.segment_count = frozen_nxt ? stored_nxt : '0;
    s1_res_nxt.dropped_count = drop_nxt;
  end

  // store: write of a new interval never meets a read of the same entry;
  // reads may address any entry, but only entries below the count are returned.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= tick_cnt_r;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      armed_r    <= 1'b0;
      await_r    <= 1'b1;
      frozen_r   <= 1'b0;
      stored_r   <= '0;
      drop_r     <= '0;
      cap_r      <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r    <= cfg_pwdata[CNT_W-1:0];
      stored_r <= '0;
      drop_r   <= '0;
      frozen_r <= 1'b0;
      await_r  <= 1'b1;
    end else begin
      tick_cnt_r <= tick_cnt_nxt;
      armed_r    <= armed_nxt;
      await_r    <= await_nxt;
      frozen_r   <= frozen_nxt;
      stored_r   <= stored_nxt;
      drop_r     <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_xfer;
      end
      if (s1_adv) begin
        out_valid <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_res_r <= s1_res_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_frame_done    <= s1_res_r.frame_done;
      out_segment_count <= s1_res_r.segment_count;
      out_dropped_count <= s1_res_r.dropped_count;
      out_read_duration <= s1_res_r.rd_hit ? mem_q_r : '0;
      out_timeout_event <= s1_res_r.timeout_event;
    end
  end

`ifndef SYNTHESIS
  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= eff_cap)
    else $error("stored count beyond capacity");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_r != '0) |-> (stored_r == eff_cap))
    else $error("intervals dropped while room was left");

  a_frozen_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    frozen_r |-> (stored_r != '0))
    else $error("frame frozen with no interval");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_res_r)))
    else $error("stage 1 lost an item under stall");

  a_timeout_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && s1_res_nxt.timeout_event && !cfg_wr) |=> !armed_r)
    else $error("timeout still armed after end of frame");
`endif

endmodule : ir_edge_interval_capture_buffer
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IR edge interval capture buffer. Tick, edge,
// release and read transfers are driven with random idling on both channels.
// A scoreboard tracks the counter, timeout and frame store, and checks every
// result transfer. Edge runs fill and overrun the store. The capacity register
// is swept from zero to its top value.
// ----------------------------------------------------------------------------
module testbench;
  import irecb_pkg::*;

  localparam int DEPTH       = DEF_STORE_DEPTH;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic              done;
    logic [CNT_W-1:0]  segs;
    logic [CNT_W-1:0]  drops;
    logic [TICK_W-1:0] dur;
    logic              tev;
  } frame_report_t;

  class frame_scoreboard;
    logic [TICK_W-1:0] tick_count;
    bit                armed;
    bit                skip_next;
    bit                frozen;
    logic [CNT_W-1:0]  stored;
    logic [CNT_W-1:0]  dropped;
    logic [CNT_W-1:0]  capacity;
    logic [TICK_W-1:0] intervals [DEPTH];
    frame_report_t     pending [$];
    int                failures;
    int                reported;

    function new();
      tick_count = '0;
      armed      = 1'b0;
      capacity   = CAP_RESET;
      failures   = 0;
      reported   = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      stored    = '0;
      dropped   = '0;
      frozen    = 1'b0;
      skip_next = 1'b1;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] value);
      capacity = value;
      restart_frame();
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [RIDX_W-1:0] idx);
      frame_report_t r;
      int room;
      r = '0;
      room = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
      case (kind)
        KIND_TICK: begin
          tick_count = tick_count + 1'b1;
          if (tick_count == '0 && armed) begin
            armed = 1'b0;
            r.tev = 1'b1;
            if (stored != '0) frozen = 1'b1;
          end
        end
        KIND_EDGE: begin
          if (!frozen) begin
            if (skip_next) begin
              skip_next = 1'b0;
            end else if (int'(stored) >= room) begin
              if (dropped != SAT_MAX) dropped = dropped + 1'b1;
            end else begin
              intervals[stored] = tick_count;
              stored = stored + 1'b1;
            end
          end
          tick_count = '0;
          armed      = 1'b1;
        end
        KIND_RELEASE: restart_frame();
        default: begin
          if (idx < stored) r.dur = intervals[idx];
        end
      endcase
      r.done  = frozen;
      r.segs  = frozen ? stored : '0;
      r.drops = dropped;
      pending.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(frame_report_t got);
      frame_report_t want;
      if (pending.size() == 0) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end
        return;
      end
      want = pending.pop_front();
      check_field("frame_done", want.done, got.done);
      check_field("segment_count", want.segs, got.segs);
      check_field("dropped_count", want.drops, got.drops);
      check_field("read_duration", want.dur, got.dur);
      check_field("timeout_event", want.tev, got.tev);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [RIDX_W-1:0]   in_read_index;
  logic                out_valid;
  logic                out_ready;
  logic                out_frame_done;
  logic [CNT_W-1:0]    out_segment_count;
  logic [CNT_W-1:0]    out_dropped_count;
  logic [TICK_W-1:0]   out_read_duration;
  logic                out_timeout_event;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [APB_AW-1:0]   cfg_paddr;
  logic [APB_DW-1:0]   cfg_pwdata;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  bit                  in_idle_on;
  bit                  out_idle_on;
  frame_scoreboard     sb;

  ir_edge_interval_capture_buffer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_done    (out_frame_done),
    .out_segment_count (out_segment_count),
    .out_dropped_count (out_dropped_count),
    .out_read_duration (out_read_duration),
    .out_timeout_event (out_timeout_event),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_frame_done, out_segment_count, out_dropped_count,
                       out_read_duration, out_timeout_event});
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(logic [KIND_W-1:0] kind, logic [RIDX_W-1:0] idx);
    if (in_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(kind, idx);
  endtask

  task automatic run_ticks(int count);
    repeat (count) send_item(KIND_TICK, RIDX_W'($urandom));
  endtask

  // edges with at most one tick between them
  task automatic edge_run(int count);
    repeat (count) begin
      run_ticks($urandom_range(0, 1));
      send_item(KIND_EDGE, RIDX_W'($urandom));
    end
  endtask

  function automatic logic [RIDX_W-1:0] pick_index();
    if (sb.stored != '0 && $urandom_range(0, 4) != 0)
      return RIDX_W'($urandom_range(0, int'(sb.stored) - 1));
    return RIDX_W'($urandom);
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_CAPACITY, 2'b00};
    cfg_pwdata  <= APB_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_capacity(value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // edges separated by short tick runs, mixed with reads of stored intervals, ticks and releases
  task automatic random_traffic(int count, int release_pct);
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        if ($urandom_range(0, 19) == 0) run_ticks($urandom_range(10, 30));
        else run_ticks($urandom_range(0, 3));
        send_item(KIND_EDGE, RIDX_W'($urandom));
      end else if (sel < 75) begin
        send_item(KIND_READ, pick_index());
      end else if (sel < 100 - release_pct) begin
        send_item(KIND_TICK, RIDX_W'($urandom));
      end else begin
        send_item(KIND_RELEASE, RIDX_W'($urandom));
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_TICK;
    in_read_index = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(KIND_READ, '0);
    send_item(KIND_READ, 7'h7F);
    run_ticks(2);
    send_item(KIND_EDGE, '0);
    send_item(KIND_EDGE, 7'h7F);
    run_ticks(5);
    send_item(KIND_EDGE, 7'h55);
    send_item(KIND_READ, 7'd1);
    send_item(KIND_READ, 7'd2);
    send_item(KIND_RELEASE, 7'h2A);
    send_item(KIND_READ, 7'd0);
    send_item(KIND_EDGE, '0);
    run_ticks(3);
    send_item(KIND_EDGE, '0);
    send_item(KIND_READ, '0);
    send_item(KIND_RELEASE, '0);

    // zero capacity: drop count runs into saturation
    write_capacity('0);
    edge_run(260);
    send_item(KIND_READ, '0);

    write_capacity(8'd1);
    random_traffic(50, 5);

    write_capacity(8'd3);
    random_traffic(60, 5);

    // capacity above the store depth: store fills, then drops
    write_capacity(8'd200);
    edge_run(135);
    random_traffic(50, 0);

    write_capacity(SAT_MAX);
    random_traffic(60, 0);

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    write_capacity(CAP_RESET);
    random_traffic(100, 2);
    settle();

    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
